// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the enhancer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("property failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/core/bsae_pkg.sv =====
// Types, codes and saturation helpers for the band split audio enhancer.
// Depends on nothing; used by every enhancer module.
`timescale 1ns / 1ps
`default_nettype none

package bsae_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFF     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_FEEDBACK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEFF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_FEEDBACK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN     = 3'd5;

	localparam logic [16:0] RST_LOW_COEFF     = 17'd637;
	localparam logic [16:0] RST_LOW_FEEDBACK  = 17'h1_04FA;
	localparam logic [16:0] RST_LOW_GAIN      = 17'd81920;
	localparam logic [16:0] RST_HIGH_COEFF    = 17'd56250;
	localparam logic [16:0] RST_HIGH_FEEDBACK = 17'h1_488E;
	localparam logic [17:0] RST_HIGH_GAIN     = 18'd116541;

	localparam logic signed [18:0] MID_GAIN = 19'sd55706;

	localparam logic [2:0] A_X     = 3'd0;
	localparam logic [2:0] A_LY_LO = 3'd1;
	localparam logic [2:0] A_LY_HI = 3'd2;
	localparam logic [2:0] A_HY_LO = 3'd3;
	localparam logic [2:0] A_HY_HI = 3'd4;
	localparam logic [2:0] A_DF_LO = 3'd5;
	localparam logic [2:0] A_DF_HI = 3'd6;

	localparam logic [2:0] B_LC  = 3'd0;
	localparam logic [2:0] B_LF  = 3'd1;
	localparam logic [2:0] B_LG  = 3'd2;
	localparam logic [2:0] B_HC  = 3'd3;
	localparam logic [2:0] B_HF  = 3'd4;
	localparam logic [2:0] B_HG  = 3'd5;
	localparam logic [2:0] B_MID = 3'd6;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	localparam logic signed [63:0] MAX40 = 64'sd549755813887;
	localparam logic signed [63:0] MIN40 = -64'sd549755813888;
	localparam logic signed [63:0] MAX26 = 64'sd33554431;
	localparam logic signed [63:0] MIN26 = -64'sd33554432;
	localparam logic signed [63:0] MAX24 = 64'sd8388607;
	localparam logic signed [63:0] MIN24 = -64'sd8388608;

	typedef struct packed {
		logic [16:0] low_coeff;
		logic [16:0] low_feedback;
		logic [16:0] low_gain;
		logic [16:0] high_coeff;
		logic [16:0] high_feedback;
		logic [17:0] high_gain;
	} coeff_t;

	typedef struct packed {
		logic       load_in;
		logic       rd_dly;
		logic [2:0] a_sel;
		logic [2:0] b_sel;
		logic [1:0] acc_op;
		logic       ld_ly;
		logic       ld_hy;
		logic       ld_diff;
		logic       wr_zl;
		logic       wr_dly;
		logic       wr_zh;
		logic       ld_mid;
		logic       ld_out;
	} cmd_t;

	typedef struct packed {
		logic in_range;
	} sts_t;

	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		logic signed [39:0] r;
		if (v > MAX40)
			r = MAX40[39:0];
		else if (v < MIN40)
			r = MIN40[39:0];
		else
			r = v[39:0];
		return r;
	endfunction

	function automatic logic signed [25:0] sat26(input logic signed [63:0] v);
		logic signed [25:0] r;
		if (v > MAX26)
			r = MAX26[25:0];
		else if (v < MIN26)
			r = MIN26[25:0];
		else
			r = v[25:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bsae_regs.sv =====
// Coefficient register bank written through the configuration port.
// Depends on bsae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsae_regs (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [bsae_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [bsae_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bsae_pkg::coeff_t                   coef
);
	import bsae_pkg::*;

	coeff_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.low_coeff     <= RST_LOW_COEFF;
			coef_q.low_feedback  <= RST_LOW_FEEDBACK;
			coef_q.low_gain      <= RST_LOW_GAIN;
			coef_q.high_coeff    <= RST_HIGH_COEFF;
			coef_q.high_feedback <= RST_HIGH_FEEDBACK;
			coef_q.high_gain     <= RST_HIGH_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_COEFF:     coef_q.low_coeff     <= cfg_data[16:0];
				REG_LOW_FEEDBACK:  coef_q.low_feedback  <= cfg_data[16:0];
				REG_LOW_GAIN:      coef_q.low_gain      <= cfg_data[16:0];
				REG_HIGH_COEFF:    coef_q.high_coeff    <= cfg_data[16:0];
				REG_HIGH_FEEDBACK: coef_q.high_feedback <= cfg_data[16:0];
				REG_HIGH_GAIN:     coef_q.high_gain     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

// ===== rtl/core/bsae_dp.sv =====
// Datapath: shared 25x19 multiplier, accumulator, per-channel filter state,
// low band delay memory and output register. Depends on bsae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsae_dp #(
	parameter int MAX_CHANNELS = 8,
	parameter int DELAY_LENGTH = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  bsae_pkg::cmd_t           cmd,
	output bsae_pkg::sts_t           sts,
	input  bsae_pkg::coeff_t         coef,
	input  wire  [2:0]               channel,
	input  wire  signed [23:0]       sample_in,
	output logic [2:0]               channel_out,
	output logic signed [23:0]       sample_out,
	output logic                     clipped
);
	import bsae_pkg::*;

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int POS_W  = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;
	localparam int DEPTH  = MAX_CHANNELS * DELAY_LENGTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [23:0] x_q;
	logic [2:0]         ch_q;
	logic signed [43:0] prod_q;
	logic signed [33:0] pl_q;
	logic signed [33:0] nh_q;
	logic signed [39:0] ly_q;
	logic signed [39:0] hy_q;
	logic signed [41:0] diff_q;
	logic signed [59:0] acc_q;
	logic signed [44:0] mid_q;
	logic signed [25:0] rd_q;
	logic               dv_q;
	logic [2:0]         channel_out_q;
	logic signed [23:0] sample_out_q;
	logic               clipped_q;

	logic signed [39:0] zl_q [MAX_CHANNELS];
	logic signed [39:0] zh_q [MAX_CHANNELS];
	logic [POS_W-1:0]   pos_q [MAX_CHANNELS];
	logic               full_q [MAX_CHANNELS];
	logic signed [25:0] dly_mem [DEPTH];

	logic [CH_W-1:0]    ch_idx;
	logic [POS_W-1:0]   pos_cur;
	logic               pos_wrap;
	logic [ADDR_W-1:0]  addr;
	logic signed [24:0] a_op;
	logic signed [18:0] b_op;
	logic signed [43:0] prod_d;
	logic signed [63:0] acc_w;
	logic signed [63:0] hterm_w;
	logic signed [63:0] out_sum;
	logic signed [63:0] out_shift;
	logic signed [25:0] d_val;
	logic signed [39:0] ly_d;
	logic signed [39:0] hy_d;
	logic signed [39:0] zl_d;
	logic signed [39:0] zh_d;
	logic signed [25:0] dly_wd;

	assign ch_idx       = CH_W'(ch_q);
	assign sts.in_range = (int'(ch_q) < MAX_CHANNELS);
	assign pos_cur      = pos_q[ch_idx];
	assign pos_wrap     = (int'(pos_cur) == DELAY_LENGTH - 1);
	assign addr         = ADDR_W'(int'(ch_idx) * DELAY_LENGTH + int'(pos_cur));

	always_comb begin
		unique case (cmd.a_sel)
			A_X:     a_op = 25'(x_q);
			A_LY_LO: a_op = $signed({4'b0, ly_q[20:0]});
			A_LY_HI: a_op = 25'($signed(ly_q[39:21]));
			A_HY_LO: a_op = $signed({4'b0, hy_q[20:0]});
			A_HY_HI: a_op = 25'($signed(hy_q[39:21]));
			A_DF_LO: a_op = $signed({4'b0, diff_q[20:0]});
			A_DF_HI: a_op = 25'($signed(diff_q[41:21]));
			default: a_op = '0;
		endcase
		unique case (cmd.b_sel)
			B_LC:    b_op = $signed({2'b0, coef.low_coeff});
			B_LF:    b_op = 19'($signed(coef.low_feedback));
			B_LG:    b_op = $signed({2'b0, coef.low_gain});
			B_HC:    b_op = $signed({2'b0, coef.high_coeff});
			B_HF:    b_op = 19'($signed(coef.high_feedback));
			B_HG:    b_op = $signed({1'b0, coef.high_gain});
			B_MID:   b_op = MID_GAIN;
			default: b_op = '0;
		endcase
	end

	assign prod_d = a_op * b_op;

	always_comb begin
		acc_w     = 64'(acc_q);
		hterm_w   = acc_w >>> 16;
		d_val     = dv_q ? rd_q : '0;
		ly_d      = sat40(64'(prod_q >>> 8) + 64'(zl_q[ch_idx]));
		hy_d      = sat40(64'(prod_q >>> 8) + 64'(zh_q[ch_idx]));
		zl_d      = sat40(64'(pl_q) - hterm_w);
		zh_d      = sat40(64'(nh_q) - hterm_w);
		dly_wd    = sat26(acc_w >>> 24);
		out_sum   = 64'(mid_q) + hterm_w;
		out_shift = out_sum >>> 8;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q  <= sample_in;
			ch_q <= channel;
		end
		prod_q <= prod_d;
		if (cmd.ld_ly) begin
			pl_q <= 34'(prod_q >>> 8);
			ly_q <= ly_d;
		end
		if (cmd.ld_hy) begin
			nh_q <= 34'((-(64'(prod_q))) >>> 8);
			hy_q <= hy_d;
		end
		if (cmd.ld_diff)
			diff_q <= 42'((64'(x_q) <<< 8) - 64'(ly_q) - 64'(hy_q));
		unique case (cmd.acc_op)
			ACC_LOAD: acc_q <= 60'(prod_q);
			ACC_ADD:  acc_q <= acc_q + (60'(prod_q) <<< 21);
			default: ;
		endcase
		if (cmd.ld_mid)
			mid_q <= 45'((64'(d_val) <<< 8) + hterm_w);
		if (cmd.ld_out) begin
			channel_out_q <= ch_q;
			if (!sts.in_range) begin
				sample_out_q <= x_q;
				clipped_q    <= 1'b0;
			end else if (out_shift > MAX24) begin
				sample_out_q <= MAX24[23:0];
				clipped_q    <= 1'b1;
			end else if (out_shift < MIN24) begin
				sample_out_q <= MIN24[23:0];
				clipped_q    <= 1'b1;
			end else begin
				sample_out_q <= out_shift[23:0];
				clipped_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_dly)
			dly_mem[addr] <= dly_wd;
		if (cmd.rd_dly)
			rd_q <= dly_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				zl_q[i]   <= '0;
				zh_q[i]   <= '0;
				pos_q[i]  <= '0;
				full_q[i] <= 1'b0;
			end
			dv_q <= 1'b0;
		end else begin
			if (cmd.rd_dly)
				dv_q <= full_q[ch_idx];
			if (cmd.wr_zl)
				zl_q[ch_idx] <= zl_d;
			if (cmd.wr_zh)
				zh_q[ch_idx] <= zh_d;
			if (cmd.wr_dly) begin
				if (pos_wrap) begin
					pos_q[ch_idx]  <= '0;
					full_q[ch_idx] <= 1'b1;
				end else begin
					pos_q[ch_idx] <= pos_cur + POS_W'(1);
				end
			end
		end
	end

	assign channel_out = channel_out_q;
	assign sample_out  = sample_out_q;
	assign clipped     = clipped_q;

endmodule

`default_nettype wire

// ===== rtl/core/bsae_ctrl.sv =====
// Controller: sequences the shared multiplier and state writes for one request.
// Depends on bsae_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsae_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  bsae_pkg::sts_t     sts,
	output bsae_pkg::cmd_t     cmd
);
	import bsae_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [3:0] K_LOW_X  = 4'd1;
	localparam logic [3:0] K_HIGH_X = 4'd2;
	localparam logic [3:0] K_LFB_LO = 4'd3;
	localparam logic [3:0] K_LFB_HI = 4'd4;
	localparam logic [3:0] K_LGN_LO = 4'd5;
	localparam logic [3:0] K_LGN_HI = 4'd6;
	localparam logic [3:0] K_HFB_LO = 4'd7;
	localparam logic [3:0] K_HFB_HI = 4'd8;
	localparam logic [3:0] K_MID_LO = 4'd9;
	localparam logic [3:0] K_MID_HI = 4'd10;
	localparam logic [3:0] K_HGN_LO = 4'd11;
	localparam logic [3:0] K_HGN_HI = 4'd12;
	localparam logic [3:0] K_LAST   = 4'd13;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [3:0] step_q;
	logic [3:0] step_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_RUN;
					step_d  = K_LOW_X;
				end
			end
			ST_RUN: begin
				step_d = step_q + 4'd1;
				unique case (step_q)
					K_LOW_X: begin
						cmd.rd_dly = 1'b1;
						cmd.a_sel  = A_X;
						cmd.b_sel  = B_LC;
						if (!sts.in_range)
							state_d = ST_DONE;
					end
					K_HIGH_X: begin
						cmd.ld_ly = 1'b1;
						cmd.a_sel = A_X;
						cmd.b_sel = B_HC;
					end
					K_LFB_LO: begin
						cmd.ld_hy = 1'b1;
						cmd.a_sel = A_LY_LO;
						cmd.b_sel = B_LF;
					end
					K_LFB_HI: begin
						cmd.ld_diff = 1'b1;
						cmd.acc_op  = ACC_LOAD;
						cmd.a_sel   = A_LY_HI;
						cmd.b_sel   = B_LF;
					end
					K_LGN_LO: begin
						cmd.acc_op = ACC_ADD;
						cmd.a_sel  = A_LY_LO;
						cmd.b_sel  = B_LG;
					end
					K_LGN_HI: begin
						cmd.wr_zl  = 1'b1;
						cmd.acc_op = ACC_LOAD;
						cmd.a_sel  = A_LY_HI;
						cmd.b_sel  = B_LG;
					end
					K_HFB_LO: begin
						cmd.acc_op = ACC_ADD;
						cmd.a_sel  = A_HY_LO;
						cmd.b_sel  = B_HF;
					end
					K_HFB_HI: begin
						cmd.wr_dly = 1'b1;
						cmd.acc_op = ACC_LOAD;
						cmd.a_sel  = A_HY_HI;
						cmd.b_sel  = B_HF;
					end
					K_MID_LO: begin
						cmd.acc_op = ACC_ADD;
						cmd.a_sel  = A_DF_LO;
						cmd.b_sel  = B_MID;
					end
					K_MID_HI: begin
						cmd.wr_zh  = 1'b1;
						cmd.acc_op = ACC_LOAD;
						cmd.a_sel  = A_DF_HI;
						cmd.b_sel  = B_MID;
					end
					K_HGN_LO: begin
						cmd.acc_op = ACC_ADD;
						cmd.a_sel  = A_HY_LO;
						cmd.b_sel  = B_HG;
					end
					K_HGN_HI: begin
						cmd.ld_mid = 1'b1;
						cmd.acc_op = ACC_LOAD;
						cmd.a_sel  = A_HY_HI;
						cmd.b_sel  = B_HG;
					end
					K_LAST: begin
						cmd.acc_op = ACC_ADD;
						state_d    = ST_DONE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.ld_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`ASSERT_PROP(a_accept_starts, clk, arst_n, (in_valid && in_ready) |=> (state_q == ST_RUN && step_q == K_LOW_X))
	`ASSERT_PROP(a_load_out_free, clk, arst_n, cmd.ld_out |-> (!out_valid_q || out_ready))
	`ASSERT_PROP(a_write_in_range, clk, arst_n, (cmd.wr_zl || cmd.wr_zh || cmd.wr_dly) |-> sts.in_range)
	`ASSERT_NEVER(a_step_bound, clk, arst_n, state_q == ST_RUN && (step_q == 4'd0 || step_q > K_LAST))

endmodule

`default_nettype wire

// ===== rtl/core/band_split_audio_enhancer.sv =====
// Top level of the band split audio enhancer: register bank, controller, datapath.
// Depends on bsae_pkg, bsae_regs, bsae_ctrl and bsae_dp.
//
//   port group   handshake              payload
//   input        in_valid / in_ready    channel, sample_in
//   output       out_valid / out_ready  channel_out, sample_out, clipped
//   config       cfg_we                 cfg_index, cfg_data
//
// An in-range request runs through accept, 13 steps of the one shared
// 25x19 multiplier (twelve partial products) and the output load. A channel
// at or beyond MAX_CHANNELS passes through and leaves filter and delay state
// as before. The next request is taken while a result waits; a stalled
// output holds ST_DONE until the output register frees. Reset clears filter
// state and delay pointers at once; the delay memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module band_split_audio_enhancer #(
	parameter int MAX_CHANNELS = 8,
	parameter int DELAY_LENGTH = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [bsae_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [bsae_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [2:0]                      channel,
	input  wire  signed [23:0]              sample_in,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [2:0]                      channel_out,
	output logic signed [23:0]              sample_out,
	output logic                            clipped
);
	import bsae_pkg::*;

	coeff_t coef;
	cmd_t   cmd;
	sts_t   sts;

	bsae_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bsae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsae_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.DELAY_LENGTH (DELAY_LENGTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.coef        (coef),
		.channel     (channel),
		.sample_in   (sample_in),
		.channel_out (channel_out),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for band_split_audio_enhancer: directed samples, then random traffic
// under eight coefficient settings, checked against an in-bench fixed-point enhancer.
// Depends on bsae_pkg and the enhancer RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int     TAPS    = 8;
	localparam longint MID_Q16 = 55706;
	localparam int     N_ROWS  = 20;

	typedef struct {
		logic [2:0]         ch;
		logic signed [23:0] smp;
		logic               clip;
	} enh_result_t;

	typedef struct {
		bit [2:0]  ch;
		bit [23:0] smp;
		bit        known;
		bit [23:0] want;
		bit        want_clip;
	} stim_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [bsae_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [bsae_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [2:0]                        channel = '0;
	logic signed [23:0]                sample_in = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [2:0]                        channel_out;
	logic signed [23:0]                sample_out;
	logic                              clipped;

	longint low_coeff_q = 637;
	longint low_fb_q = -64262;
	longint low_gain_q = 81920;
	longint high_coeff_q = 56250;
	longint high_fb_q = -46962;
	longint high_gain_q = 116541;

	longint lp_mem [8];
	longint hp_mem [8];
	longint low_delay [8][TAPS];
	int     tap_pos [8];

	enh_result_t expected_samples [$];
	enh_result_t head_result;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int sent_count = 0;
	int checked_count = 0;

	stim_row_t directed_rows [N_ROWS] = '{
		'{3'd0, 24'h000000, 1'b1, 24'h000000, 1'b0},
		'{3'd7, 24'h000000, 1'b1, 24'h000000, 1'b0},
		'{3'd1, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd1, 24'h800000, 1'b0, 24'h0, 1'b0},
		'{3'd2, 24'h800000, 1'b0, 24'h0, 1'b0},
		'{3'd2, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h7FFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd3, 24'h800000, 1'b0, 24'h0, 1'b0},
		'{3'd4, 24'h000001, 1'b0, 24'h0, 1'b0},
		'{3'd5, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
		'{3'd6, 24'h555555, 1'b0, 24'h0, 1'b0},
		'{3'd6, 24'hAAAAAA, 1'b0, 24'h0, 1'b0}
	};

	band_split_audio_enhancer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel_out (channel_out),
		.sample_out  (sample_out),
		.clipped     (clipped)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic enh_result_t enhance_sample(input logic [2:0] ch,
			input logic signed [23:0] xs);
		longint x;
		longint lterm;
		longint ly;
		longint hy;
		longint d;
		longint mid;
		longint hterm;
		longint s;
		enh_result_t r;
		x = xs;
		lterm = (low_coeff_q * x) >>> 8;
		ly = clamp(lterm + lp_mem[ch], 40);
		lp_mem[ch] = clamp(lterm - ((low_fb_q * ly) >>> 16), 40);
		d = low_delay[ch][tap_pos[ch]];
		low_delay[ch][tap_pos[ch]] = clamp((ly * low_gain_q) >>> 24, 26);
		tap_pos[ch] = (tap_pos[ch] + 1) % TAPS;
		hy = clamp(((high_coeff_q * x) >>> 8) + hp_mem[ch], 40);
		hp_mem[ch] = clamp(((-(high_coeff_q * x)) >>> 8) - ((high_fb_q * hy) >>> 16), 40);
		mid = ((x * 256 - ly - hy) * MID_Q16) >>> 16;
		hterm = (hy * high_gain_q) >>> 16;
		s = (d * 256 + mid + hterm) >>> 8;
		r.ch = ch;
		r.clip = 1'b0;
		if (s > 64'sd8388607) begin
			s = 64'sd8388607;
			r.clip = 1'b1;
		end
		if (s < -64'sd8388608) begin
			s = -64'sd8388608;
			r.clip = 1'b1;
		end
		r.smp = s[23:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	task automatic write_reg(input logic [bsae_pkg::CFG_IDX_W-1:0] idx, input longint val);
		logic [17:0]        raw;
		logic signed [16:0] sv;
		raw = val[17:0];
		sv = raw[16:0];
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= raw;
		@(posedge clk);
		case (idx)
			bsae_pkg::REG_LOW_COEFF:     low_coeff_q = longint'(raw[16:0]);
			bsae_pkg::REG_LOW_FEEDBACK:  low_fb_q = longint'(sv);
			bsae_pkg::REG_LOW_GAIN:      low_gain_q = longint'(raw[16:0]);
			bsae_pkg::REG_HIGH_COEFF:    high_coeff_q = longint'(raw[16:0]);
			bsae_pkg::REG_HIGH_FEEDBACK: high_fb_q = longint'(sv);
			bsae_pkg::REG_HIGH_GAIN:     high_gain_q = longint'(raw);
			default: ;
		endcase
	endtask

	task automatic apply_settings(input longint lc, input longint lf, input longint lg,
			input longint hc, input longint hf, input longint hg);
		write_reg(bsae_pkg::REG_LOW_COEFF, lc);
		write_reg(bsae_pkg::REG_LOW_FEEDBACK, lf);
		write_reg(bsae_pkg::REG_LOW_GAIN, lg);
		write_reg(bsae_pkg::REG_HIGH_COEFF, hc);
		write_reg(bsae_pkg::REG_HIGH_FEEDBACK, hf);
		write_reg(bsae_pkg::REG_HIGH_GAIN, hg);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic [2:0] ch, input logic [23:0] smp, input bit known,
			input logic [23:0] want, input logic want_clip);
		enh_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample_in <= smp;
		do
			@(posedge clk);
		while (!in_ready);
		r = enhance_sample(ch, smp);
		if (known) begin
			r.smp = want;
			r.clip = want_clip;
		end
		expected_samples.push_back(r);
		sent_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: ch %0d sample %0d",
					channel_out, sample_out));
			end else begin
				head_result = expected_samples.pop_front();
				if (channel_out !== head_result.ch)
					report_mismatch($sformatf("channel_out %0d, want %0d",
						channel_out, head_result.ch));
				if (sample_out !== head_result.smp)
					report_mismatch($sformatf("ch %0d sample_out %0d, want %0d",
						head_result.ch, sample_out, head_result.smp));
				if (clipped !== head_result.clip)
					report_mismatch($sformatf("ch %0d clipped %0b, want %0b",
						head_result.ch, clipped, head_result.clip));
				checked_count++;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		int         phase;
		int         k;
		int         pick;
		logic [31:0] rnd;
		logic [2:0]  ch;
		logic [23:0] smp;
		logic [2:0]  last_ch;
		logic [23:0] last_smp;
		last_ch = '0;
		last_smp = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_ROWS; k++)
			send_sample(directed_rows[k].ch, directed_rows[k].smp, directed_rows[k].known,
				directed_rows[k].want, directed_rows[k].want_clip);

		for (phase = 0; phase < 8; phase++) begin
			in_valid <= 1'b0;
			while (expected_samples.size() != 0)
				@(posedge clk);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			case (phase)
				0: apply_settings(637, -64262, 81920, 56250, -46962, 116541);
				1: apply_settings(0, -65536, 65536, 0, -65536, 65536);
				2: apply_settings(65536, 0, 98304, 65536, 0, 207243);
				3, 6: apply_settings($urandom_range(0, 262143), $urandom_range(0, 262143),
					$urandom_range(0, 262143), $urandom_range(0, 262143),
					$urandom_range(0, 262143), $urandom_range(0, 262143));
				4: apply_settings($urandom_range(0, 65536), -longint'($urandom_range(0, 65536)),
					$urandom_range(65536, 98304), $urandom_range(0, 65536),
					-longint'($urandom_range(0, 65536)), $urandom_range(65536, 207243));
				5: apply_settings(65536, -65536, 98304, 65536, -65536, 207243);
				default: apply_settings(131071, 65535, 131071, 131071, 65535, 262143);
			endcase
			for (k = 0; k < 150; k++) begin
				rnd = $urandom;
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					ch = rnd[26:24];
					smp = rnd[23:0];
				end else if (pick < 6) begin
					ch = rnd[2:0];
					smp = rnd[3] ? 24'h7FFFFF : 24'h800000;
				end else if (pick < 8) begin
					ch = rnd[2:0];
					smp = {{15{rnd[8]}}, rnd[8:0]};
				end else begin
					ch = last_ch;
					smp = last_smp;
				end
				last_ch = ch;
				last_smp = smp;
				send_sample(ch, smp, 1'b0, '0, 1'b0);
			end
		end

		in_valid <= 1'b0;
		for (k = 0; k < 5000 && expected_samples.size() != 0; k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_samples.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_samples.size()));
		$display("Ran %0d samples across 8 coefficient settings and 4 flow-control mixes;",
			sent_count);
		$display("%0d results compared, %0d mismatches.", checked_count, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
